>>> design/tccw_pkg.sv
// Shared constants, types and codes for the text console character writer.
`default_nettype none
package tccw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int OFFSET_W = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int WIDE_W   = (ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W;

  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0e20;
  localparam logic [CELL_W-1:0] ATTR_MASK   = 16'hff00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN   = 8'd13;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } st_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

>>> design/tccw_screen_ram.sv
// Screen cell store: one write port, one registered read port.
`default_nettype none
module tccw_screen_ram
  import tccw_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_req_t          req,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/tccw_ctrl.sv
// Command sequencer: cursor, rotating row base, row clear and result register.
`default_nettype none
module tccw_ctrl
  import tccw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic [CHAR_W-1:0]   in_char,
  input  wire logic [OFFSET_W-1:0] in_addr,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [OFFSET_W-1:0] out_offset,
  output logic      [CELL_W-1:0]   out_cell,
  output logic                     out_scrolled,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CELL_W-1:0]   cfg_data,
  output ram_req_t                 ram_req,
  input  wire logic [CELL_W-1:0]   ram_rdata
);

  st_t               state, state_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] clr_base;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  line;
  logic [ADDR_W-1:0] line_off;
  logic [ADDR_W-1:0] base_off;
  logic [CELL_W-1:0] default_cell;
  logic              read_oob;

  logic              accept, is_nl, is_cr, wrap, adv_line, do_scroll;
  logic [COL_W:0]    col_inc;
  logic [COL_W-1:0]  col_put;
  logic [ADDR_W-1:0] line_off_put;
  logic [ADDR_W-1:0] off_put, off_cur;
  logic [WIDE_W-1:0] off_put_w, off_cur_w, addr_w;
  logic [ADDR_W:0]   wsum, rsum, bsum;
  logic [ADDR_W-1:0] wphys, rphys, base_next;
  logic              in_range;
  logic              cnt_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  assign is_nl     = (in_char == CH_NEWLINE);
  assign is_cr     = (in_char == CH_RETURN);
  assign col_inc   = {1'b0, col} + (COL_W+1)'(1);
  assign wrap      = (col_inc == (COL_W+1)'(COLUMNS));
  assign adv_line  = is_nl || (!is_cr && wrap);
  assign col_put   = (is_nl || is_cr || wrap) ? '0 : col_inc[COL_W-1:0];
  assign do_scroll = adv_line && (line == ROW_W'(ROWS - 1));
  assign line_off_put = (adv_line && !do_scroll) ? line_off + ADDR_W'(COLUMNS) : line_off;

  assign off_put   = line_off_put + ADDR_W'(col_put);
  assign off_cur   = line_off + ADDR_W'(col);
  assign off_put_w = WIDE_W'(off_put);
  assign off_cur_w = WIDE_W'(off_cur);

  assign wsum  = {1'b0, line_off} + (ADDR_W+1)'(col) + {1'b0, base_off};
  assign wphys = (wsum >= (ADDR_W+1)'(CELLS)) ? ADDR_W'(wsum - (ADDR_W+1)'(CELLS))
                                              : wsum[ADDR_W-1:0];

  assign addr_w   = WIDE_W'(in_addr);
  assign in_range = (addr_w < WIDE_W'(CELLS));
  assign rsum     = {1'b0, addr_w[ADDR_W-1:0]} + {1'b0, base_off};
  assign rphys    = (rsum >= (ADDR_W+1)'(CELLS)) ? ADDR_W'(rsum - (ADDR_W+1)'(CELLS))
                                                 : rsum[ADDR_W-1:0];

  assign bsum      = {1'b0, base_off} + (ADDR_W+1)'(COLUMNS);
  assign base_next = (bsum >= (ADDR_W+1)'(CELLS)) ? ADDR_W'(bsum - (ADDR_W+1)'(CELLS))
                                                  : bsum[ADDR_W-1:0];

  always_comb begin
    unique case (state)
      ST_INIT:  cnt_last = (cnt == ADDR_W'(CELLS - 1));
      ST_CLEAR: cnt_last = (cnt == ADDR_W'(COLUMNS - 1));
      default:  cnt_last = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_READ) state_next = ST_READ;
          else if (do_scroll)     state_next = ST_CLEAR;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_CLEAR: begin
        if (cnt_last) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ram_req = '0;
    unique case (state)
      ST_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt;
        ram_req.wdata = BLANK_RESET;
      end
      ST_IDLE: begin
        ram_req.we    = accept && (in_cmd == CMD_PUT) && !is_nl && !is_cr;
        ram_req.waddr = wphys;
        ram_req.wdata = (default_cell & ATTR_MASK) | CELL_W'(in_char);
        ram_req.re    = accept && (in_cmd == CMD_READ);
        ram_req.raddr = rphys;
      end
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_base + cnt;
        ram_req.wdata = default_cell;
      end
      default: ram_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      cnt          <= '0;
      col          <= '0;
      line         <= ROW_W'(ROWS - 1);
      line_off     <= ADDR_W'((ROWS - 1) * COLUMNS);
      base_off     <= '0;
      default_cell <= BLANK_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) default_cell <= cfg_data;

      if (state == ST_INIT || state == ST_CLEAR) begin
        cnt <= cnt_last ? '0 : cnt + ADDR_W'(1);
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      if (accept) begin
        if (in_cmd == CMD_PUT) begin
          out_valid <= 1'b1;
          col       <= col_put;
          line_off  <= line_off_put;
          if (adv_line && !do_scroll) line <= line + ROW_W'(1);
          if (do_scroll) base_off <= base_next;
        end
      end

      if (state == ST_READ) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_cmd == CMD_PUT) begin
        out_offset   <= off_put_w[OFFSET_W-1:0];
        out_cell     <= '0;
        out_scrolled <= do_scroll;
        clr_base     <= base_off;
      end else begin
        out_offset   <= off_cur_w[OFFSET_W-1:0];
        out_scrolled <= 1'b0;
        read_oob     <= !in_range;
      end
    end
    if (state == ST_READ) begin
      out_cell <= read_oob ? '0 : ram_rdata;
    end
  end

endmodule
`default_nettype wire

>>> design/text_console_char_writer.sv
// Top level of the text console character writer.
//
//   channel  | direction | handshake                     | payload
//   s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata char, address; tuser command
//   m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata offset, cell; tuser scrolled
//   cfg      | in        | cfg_valid / cfg_ready         | cfg_data default cell
//
// A put that scrolls also clears the new bottom row, COLUMNS (80) cells, through the
// single write port of the cell memory. A read passes through ST_READ for the registered
// memory read. After reset a clearing pass writes all CELLS (2000) entries, one a cycle,
// with s_axis_tready low; cfg writes are taken at any time.
// An item is taken only when the result register is empty or being emptied.
`default_nettype none
module text_console_char_writer
  import tccw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] char_code, [18:8] cell_address, rest 0
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [10:0] cursor_offset, [26:11] cell_value, rest 0
  output logic             m_axis_tuser,   // [0] scrolled
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  ram_req_t              ram_req;
  logic [CELL_W-1:0]     ram_rdata;
  logic [OFFSET_W-1:0]   out_offset;
  logic [CELL_W-1:0]     out_cell;

  tccw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_cmd       (s_axis_tuser),
    .in_char      (s_axis_tdata[7:0]),
    .in_addr      (s_axis_tdata[18:8]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_offset   (out_offset),
    .out_cell     (out_cell),
    .out_scrolled (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  tccw_screen_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign m_axis_tdata = {5'd0, out_cell, out_offset};

endmodule
`default_nettype wire

>>> design/tccw_checker.sv
// Port-level assertions for the text console character writer, bound to the top level.
`default_nettype none
module tccw_checker
  import tccw_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken while result register full");

  a_put_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_axis_tuser == CMD_PUT) |=> m_axis_tvalid && (m_axis_tdata[26:11] == 16'd0))
    else $error("put transfer did not yield a result");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_axis_tuser == CMD_READ) |=> !s_axis_tready ##1 m_axis_tvalid)
    else $error("read transfer sequencing wrong");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (WIDE_W'(m_axis_tdata[10:0]) < WIDE_W'(CELLS)) || (CELLS > 2048))
    else $error("cursor offset beyond grid");

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (.*);
`default_nettype wire
